// ===== rtl/cpd_pkg.sv =====
// Package with payload types, register indexes and controller command codes.
package cpd_pkg;

	typedef struct packed {
		logic signed [15:0] corr_re;
		logic signed [15:0] corr_im;
		logic [31:0]        blk_energy;
		logic               last;
	} in_beat_t;

	typedef struct packed {
		logic               detected;
		logic [15:0]        peak_index;
		logic signed [15:0] frac_offset;
		logic [31:0]        peak_pwr;
		logic [31:0]        noise_est;
		logic [31:0]        threshold;
	} out_beat_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STOP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_OFFSET   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_GAIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE_ENERGY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH    = 3'd5;

	// Datapath operations issued by the controller.
	localparam logic [3:0] OP_NONE      = 4'd0;
	localparam logic [3:0] OP_MUL       = 4'd1;
	localparam logic [3:0] OP_NSUB      = 4'd2;
	localparam logic [3:0] OP_NDIV      = 4'd3;
	localparam logic [3:0] OP_GMUL      = 4'd4;
	localparam logic [3:0] OP_THR       = 4'd5;
	localparam logic [3:0] OP_DECIDE    = 4'd6;
	localparam logic [3:0] OP_LOG_START = 4'd7;
	localparam logic [3:0] OP_LOG_STORE = 4'd8;
	localparam logic [3:0] OP_OPREP     = 4'd9;
	localparam logic [3:0] OP_ODIV      = 4'd10;
	localparam logic [3:0] OP_OFIN      = 4'd11;
	localparam logic [3:0] OP_EMIT      = 4'd12;

	localparam logic [1:0] SEL_LEFT  = 2'd0;
	localparam logic [1:0] SEL_PEAK  = 2'd1;
	localparam logic [1:0] SEL_RIGHT = 2'd2;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic end_blk;
		logic div_busy;
		logic norm_done;
		logic go_off;
		logic den_zero;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/cpd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module cpd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [5:0]  steps,
	input  logic [24:0] rem_init,
	input  logic [63:0] dividend,
	input  logic [24:0] divisor,
	output logic        busy,
	output logic [63:0] quotient
);

	logic [24:0] rem_q;
	logic [63:0] dq_q;
	logic [24:0] dvs_q;
	logic [5:0]  cnt_q;
	logic [25:0] trial;
	logic        fits;

	assign trial = {rem_q, dq_q[63]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign busy  = cnt_q != 6'd0;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? 25'(trial - {1'b0, dvs_q}) : trial[24:0];
			dq_q  <= {dq_q[62:0], fits};
		end
	end

endmodule

// ===== rtl/cpd_dp.sv =====
// Datapath: configuration, sample power and peak tracking, end-of-block arithmetic.
module cpd_dp #(
	parameter int MAX_BLOCK      = 65536,
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cpd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  cpd_pkg::in_beat_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output cpd_pkg::out_beat_t              out_data,
	input  cpd_pkg::cmd_t                   cmd,
	output cpd_pkg::stat_t                  stat
);

	localparam int CNT_W = $clog2(MAX_BLOCK);
	localparam int TAB_N = 1 << LOG_TABLE_BITS;

	// Log table: log2(1 + idx/TAB_N) in Q.16, by repeated squaring in Q2.30.
	function automatic logic [TAB_N*16-1:0] build_tab();
		logic [TAB_N*16-1:0] t;
		logic [63:0] x;
		logic [15:0] r;
		t = '0;
		for (int i = 0; i < TAB_N; i++) begin
			x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
			r = '0;
			for (int k = 0; k < 16; k++) begin
				x = (x * x) >> 30;
				r = r << 1;
				if (x >= (64'd2 << 30)) begin
					x = x >> 1;
					r = r | 16'd1;
				end
			end
			t[i*16 +: 16] = r;
		end
		return t;
	endfunction

	localparam logic [TAB_N*16-1:0] LOG_TAB = build_tab();

	// Configuration registers.
	logic [15:0] ws_q;
	logic [16:0] wstop_q;
	logic [31:0] toff_q;
	logic [15:0] gain_q;
	logic [31:0] te_q;
	logic [16:0] bl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= '0;
			wstop_q <= 17'h10000;
			toff_q  <= '0;
			gain_q  <= 16'd256;
			te_q    <= '0;
			bl_q    <= 17'h10000;
		end else if (cfg_we) begin
			case (cfg_index)
				cpd_pkg::REG_WINDOW_START:    ws_q    <= cfg_data[15:0];
				cpd_pkg::REG_WINDOW_STOP:     wstop_q <= cfg_data[16:0];
				cpd_pkg::REG_THRESH_OFFSET:   toff_q  <= cfg_data;
				cpd_pkg::REG_THRESH_GAIN:     gain_q  <= cfg_data[15:0];
				cpd_pkg::REG_TEMPLATE_ENERGY: te_q    <= cfg_data;
				cpd_pkg::REG_BLOCK_LENGTH:    bl_q    <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Input stage: power of each sample.
	logic             in_fire;
	logic             blk_q;
	logic [CNT_W-1:0] cnt_q;
	logic             v_s1, last_s1;
	logic [31:0]      p_s1;
	logic [15:0]      idx_s1;
	logic [31:0]      se_q;
	logic             end_q;

	assign in_fire  = in_valid && !in_stall;
	assign in_stall = blk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q <= 1'b0;
			cnt_q <= '0;
			v_s1  <= 1'b0;
			end_q <= 1'b0;
		end else begin
			v_s1  <= in_fire;
			end_q <= v_s1 && last_s1;
			if (in_fire && in_data.last) begin
				blk_q <= 1'b1;
			end else if (cmd.op == cpd_pkg::OP_EMIT && stat.out_free) begin
				blk_q <= 1'b0;
			end
			if (in_fire) begin
				if (in_data.last || cnt_q == CNT_W'(MAX_BLOCK - 1)) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			p_s1    <= 32'(in_data.corr_re * in_data.corr_re)
			         + 32'(in_data.corr_im * in_data.corr_im);
			idx_s1  <= 16'(cnt_q);
			last_s1 <= in_data.last;
			if (in_data.last) begin
				se_q <= in_data.blk_energy;
			end
		end
	end

	// Peak tracking over the search window.
	logic [31:0] best_q, left_q, right_q, prev_q;
	logic [15:0] bidx_q;
	logic        have_q, cap_q;
	logic [31:0] best_n, left_n, right_n;
	logic [15:0] bidx_n;
	logic        have_n, cap_n, in_win;

	assign in_win = idx_s1 >= ws_q && {1'b0, idx_s1} < wstop_q;

	always_comb begin
		best_n  = best_q;
		left_n  = left_q;
		right_n = cap_q ? p_s1 : right_q;
		bidx_n  = bidx_q;
		have_n  = have_q;
		cap_n   = 1'b0;
		if (in_win && (!have_q || p_s1 > best_q)) begin
			best_n = p_s1;
			bidx_n = idx_s1;
			have_n = 1'b1;
			left_n = prev_q;
			cap_n  = 1'b1;
		end
	end

	// Values of the finished block, held for the end-of-block work.
	logic [31:0] e_best, e_left, e_right;
	logic [15:0] e_idx;
	logic        e_have, e_cap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0; left_q <= '0; right_q <= '0; prev_q <= '0;
			bidx_q <= '0; have_q <= 1'b0; cap_q <= 1'b0;
		end else if (v_s1) begin
			if (last_s1) begin
				best_q <= '0; left_q <= '0; right_q <= '0; prev_q <= '0;
				bidx_q <= '0; have_q <= 1'b0; cap_q <= 1'b0;
			end else begin
				best_q <= best_n; left_q <= left_n; right_q <= right_n;
				prev_q <= p_s1; bidx_q <= bidx_n; have_q <= have_n; cap_q <= cap_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && last_s1) begin
			e_best <= best_n; e_left <= left_n; e_right <= right_n;
			e_idx <= bidx_n; e_have <= have_n; e_cap <= cap_n;
		end
	end

	// End-of-block arithmetic.
	logic [63:0] prod_q;
	logic [63:0] pk;
	logic [16:0] blx;
	logic        sat_q;
	logic [31:0] noise_q, noise_v;
	logic [47:0] gp_q;
	logic [40:0] thr_sum;
	logic [31:0] thr_q;
	logic        det_q;
	logic [31:0] norm_q;
	logic [4:0]  exp_q;
	logic [20:0] la_q, lb_q, lc_q, lval;
	logic [LOG_TABLE_BITS-1:0] tidx;
	logic signed [36:0] num_q;
	logic signed [24:0] den_q;
	logic signed [21:0] dl;
	logic signed [23:0] dt;
	logic [36:0] num_abs;
	logic [24:0] den_abs;
	logic [35:0] qmag;
	logic [15:0] qclip;
	logic signed [15:0] off_q;
	logic [31:0] sel_val;

	logic        div_start;
	logic [5:0]  div_steps;
	logic [24:0] div_rem, div_dvs;
	logic [63:0] div_dvd, div_q;
	logic        div_busy;

	assign pk      = {30'd0, e_best, 2'b00};
	assign blx     = (bl_q == 17'd0) ? 17'd1 : bl_q;
	assign noise_v = sat_q ? 32'hFFFF_FFFF : div_q[31:0];
	assign thr_sum = {9'd0, toff_q} + {1'b0, gp_q[47:8]};
	assign tidx    = norm_q[30 -: LOG_TABLE_BITS];
	assign lval    = {exp_q, LOG_TAB[tidx*16 +: 16]};
	assign dl      = $signed({1'b0, lc_q}) - $signed({1'b0, la_q});
	assign dt      = $signed({2'b00, lb_q, 1'b0}) - $signed({3'b000, la_q})
	               - $signed({3'b000, lc_q});
	assign num_abs = num_q[36] ? 37'(-num_q) : 37'(num_q);
	assign den_abs = den_q[24] ? 25'(-den_q) : 25'(den_q);
	assign qmag    = div_q[35:0];
	assign qclip   = (qmag > 36'd16384) ? 16'd16384 : 16'(qmag);

	always_comb begin
		unique case (cmd.sel)
			cpd_pkg::SEL_LEFT:  sel_val = e_left;
			cpd_pkg::SEL_PEAK:  sel_val = e_best;
			default:            sel_val = e_right;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_steps = 6'd32;
		div_rem   = prod_q[56:32];
		div_dvd   = {prod_q[31:0], 32'd0};
		div_dvs   = {8'd0, blx};
		if (cmd.op == cpd_pkg::OP_NDIV) begin
			div_start = 1'b1;
		end else if (cmd.op == cpd_pkg::OP_ODIV) begin
			div_start = 1'b1;
			div_steps = 6'd36;
			div_rem   = '0;
			div_dvd   = {num_abs[35:0], 28'd0};
			div_dvs   = den_abs;
		end
	end

	cpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.steps    (div_steps),
		.rem_init (div_rem),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		// The leading-one search shifts by one place a cycle until bit 31 is set.
		if (cmd.op == cpd_pkg::OP_LOG_START) begin
			norm_q <= sel_val;
			exp_q  <= 5'd31;
		end else if (!norm_q[31]) begin
			norm_q <= {norm_q[30:0], 1'b0};
			exp_q  <= exp_q - 5'd1;
		end
		unique case (cmd.op)
			cpd_pkg::OP_MUL:    prod_q <= 64'(se_q) * 64'(te_q);
			cpd_pkg::OP_NSUB:   prod_q <= (prod_q > pk) ? {2'b00, 62'((prod_q - pk) >> 2)}
			                                           : 64'd0;
			cpd_pkg::OP_NDIV:   sat_q <= prod_q[61:32] >= {13'd0, blx};
			cpd_pkg::OP_GMUL: begin
				noise_q <= noise_v;
				gp_q    <= 48'(gain_q) * 48'(noise_v);
			end
			cpd_pkg::OP_THR:    thr_q <= (|thr_sum[40:32]) ? 32'hFFFF_FFFF : thr_sum[31:0];
			cpd_pkg::OP_DECIDE: begin
				det_q <= e_best > thr_q;
				off_q <= '0;
			end
			cpd_pkg::OP_LOG_STORE: begin
				unique case (cmd.sel)
					cpd_pkg::SEL_LEFT: la_q <= lval;
					cpd_pkg::SEL_PEAK: lb_q <= lval;
					default:           lc_q <= lval;
				endcase
			end
			cpd_pkg::OP_OPREP: begin
				num_q <= {dl, 15'd0};
				den_q <= {dt, 1'b0};
			end
			cpd_pkg::OP_OFIN:   off_q <= (num_q[36] ^ den_q[24]) ? 16'(-qclip) : qclip;
			default: ;
		endcase
	end

	// Output register.
	cpd_pkg::out_beat_t out_q;
	logic               out_v_q;

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.op == cpd_pkg::OP_EMIT && stat.out_free) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == cpd_pkg::OP_EMIT && stat.out_free) begin
			out_q.detected    <= det_q;
			out_q.peak_index  <= e_idx;
			out_q.frac_offset <= off_q;
			out_q.peak_pwr    <= e_best;
			out_q.noise_est   <= noise_q;
			out_q.threshold   <= thr_q;
		end
	end

	assign stat.end_blk   = end_q;
	assign stat.div_busy  = div_busy;
	assign stat.norm_done = norm_q[31];
	assign stat.go_off    = det_q && e_have && e_idx != 16'd0 && !e_cap
	                     && e_left != 32'd0 && e_best != 32'd0 && e_right != 32'd0;
	assign stat.den_zero  = den_q == 25'sd0;
	assign stat.out_free  = !out_v_q || !out_stall;

endmodule

// ===== rtl/cpd_ctrl.sv =====
// Controller that sequences the end-of-block work in the datapath.
module cpd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  cpd_pkg::stat_t stat,
	output cpd_pkg::cmd_t  cmd
);

	localparam logic [3:0] ST_RUN    = 4'd0;
	localparam logic [3:0] ST_MUL    = 4'd1;
	localparam logic [3:0] ST_NSUB   = 4'd2;
	localparam logic [3:0] ST_NDIV   = 4'd3;
	localparam logic [3:0] ST_NWAIT  = 4'd4;
	localparam logic [3:0] ST_GMUL   = 4'd5;
	localparam logic [3:0] ST_THR    = 4'd6;
	localparam logic [3:0] ST_DECIDE = 4'd7;
	localparam logic [3:0] ST_CHOOSE = 4'd8;
	localparam logic [3:0] ST_LOGS   = 4'd9;
	localparam logic [3:0] ST_LOGW   = 4'd10;
	localparam logic [3:0] ST_OPREP  = 4'd11;
	localparam logic [3:0] ST_OCHK   = 4'd12;
	localparam logic [3:0] ST_OWAIT  = 4'd13;
	localparam logic [3:0] ST_OFIN   = 4'd14;
	localparam logic [3:0] ST_EMIT   = 4'd15;

	logic [3:0] state_q, state_n;
	logic [1:0] sel_q, sel_n;

	always_comb begin
		state_n = state_q;
		sel_n   = sel_q;
		cmd.op  = cpd_pkg::OP_NONE;
		cmd.sel = sel_q;
		unique case (state_q)
			ST_RUN:    if (stat.end_blk) state_n = ST_MUL;
			ST_MUL:    begin cmd.op = cpd_pkg::OP_MUL;  state_n = ST_NSUB; end
			ST_NSUB:   begin cmd.op = cpd_pkg::OP_NSUB; state_n = ST_NDIV; end
			ST_NDIV:   begin cmd.op = cpd_pkg::OP_NDIV; state_n = ST_NWAIT; end
			ST_NWAIT:  if (!stat.div_busy) state_n = ST_GMUL;
			ST_GMUL:   begin cmd.op = cpd_pkg::OP_GMUL; state_n = ST_THR; end
			ST_THR:    begin cmd.op = cpd_pkg::OP_THR;  state_n = ST_DECIDE; end
			ST_DECIDE: begin cmd.op = cpd_pkg::OP_DECIDE; state_n = ST_CHOOSE; end
			ST_CHOOSE: begin
				sel_n   = cpd_pkg::SEL_LEFT;
				state_n = stat.go_off ? ST_LOGS : ST_EMIT;
			end
			ST_LOGS:   begin cmd.op = cpd_pkg::OP_LOG_START; state_n = ST_LOGW; end
			ST_LOGW: begin
				if (stat.norm_done) begin
					cmd.op = cpd_pkg::OP_LOG_STORE;
					if (sel_q == cpd_pkg::SEL_RIGHT) begin
						state_n = ST_OPREP;
					end else begin
						sel_n   = sel_q + 2'd1;
						state_n = ST_LOGS;
					end
				end
			end
			ST_OPREP:  begin cmd.op = cpd_pkg::OP_OPREP; state_n = ST_OCHK; end
			ST_OCHK: begin
				// A flat peak leaves the offset at zero.
				if (stat.den_zero) begin
					state_n = ST_EMIT;
				end else begin
					cmd.op  = cpd_pkg::OP_ODIV;
					state_n = ST_OWAIT;
				end
			end
			ST_OWAIT:  if (!stat.div_busy) state_n = ST_OFIN;
			ST_OFIN:   begin cmd.op = cpd_pkg::OP_OFIN; state_n = ST_EMIT; end
			ST_EMIT: begin
				cmd.op = cpd_pkg::OP_EMIT;
				if (stat.out_free) state_n = ST_RUN;
			end
			default:   state_n = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			sel_q   <= cpd_pkg::SEL_LEFT;
		end else begin
			state_q <= state_n;
			sel_q   <= sel_n;
		end
	end

endmodule

// ===== rtl/correlation_peak_detector_unit.sv =====
// Top level of the correlation peak detector.
// Samples are taken one per cycle while in_stall is low; the power of a beat is registered in the cycle after it.
// After the last beat of a block, input stalls for the end-of-block work: the noise
// division (32 steps), then, when an offset is worked out, three leading-one searches and,
// for a non-flat peak, the offset division (36 steps), and any wait for the previous result
// to leave the output register; input is taken again once the result is loaded.
module correlation_peak_detector_unit #(
	parameter int MAX_BLOCK      = 65536,
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cpd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  cpd_pkg::in_beat_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output cpd_pkg::out_beat_t              out_data
);

	// Reset clears configuration to defaults and the input, peak and control state; no clearing pass.
	cpd_pkg::cmd_t  cmd;
	cpd_pkg::stat_t stat;

	cpd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	cpd_dp #(
		.MAX_BLOCK      (MAX_BLOCK),
		.LOG_TABLE_BITS (LOG_TABLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== rtl/cpd_checker.sv =====
// Port-level checker for the correlation peak detector, bound to the top level.
module cpd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input cpd_pkg::in_beat_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input cpd_pkg::out_beat_t out_data
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_no_off_undet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.detected |-> out_data.frac_offset == 16'sd0)
		else $error("offset set on an undetected peak");

	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.frac_offset >= -16'sd16384 && out_data.frac_offset <= 16'sd16384)
		else $error("offset outside half a sample");

	a_det_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.detected == (out_data.peak_pwr > out_data.threshold))
		else $error("detect flag disagrees with threshold");

	// The block end holds off further samples while the result is worked out.
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.last |=> in_stall)
		else $error("input taken right after block end");

endmodule

bind correlation_peak_detector_unit cpd_checker u_cpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
